// File: sv/elf_hash_bin_index_core_assert.svh
// assertion macros for the elf hash bin index core
`ifndef ELF_HASH_BIN_INDEX_CORE_ASSERT_SVH
`define ELF_HASH_BIN_INDEX_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define EHBI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define EHBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ehbi_pkg.sv
package ehbi_pkg;

  localparam int HASH_W      = 32;
  localparam int BIN_W       = 31;
  localparam int STEP_SHIFT  = 4;
  localparam int FOLD_SHIFT  = 24;
  localparam logic [HASH_W-1:0] TOP_NIBBLE_MASK = 32'hf000_0000;
  localparam logic [BIN_W-1:0]  BIN_COUNT_RESET = 31'd1;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] acc,
                                                  input logic [HASH_W-1:0] elem);
    logic [HASH_W-1:0] sum;
    logic [HASH_W-1:0] top;
    sum = (acc << STEP_SHIFT) + elem;
    top = sum & TOP_NIBBLE_MASK;
    return sum ^ (top >> FOLD_SHIFT) ^ top;
  endfunction

endpackage

// File: sv/ehbi_in_if.sv
interface ehbi_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ehbi_pkg::HASH_W-1:0] key_element;
  logic                              element_present;
  logic                              key_end;

  modport source (output valid, output key_element, output element_present,
                  output key_end, input ready);
  modport sink (input valid, input key_element, input element_present,
                input key_end, output ready);
endinterface

// File: sv/ehbi_out_if.sv
interface ehbi_out_if;
  logic                       valid;
  logic                       ready;
  logic [ehbi_pkg::BIN_W-1:0] bin_index;

  modport source (output valid, output bin_index, input ready);
  modport sink (input valid, input bin_index, output ready);
endinterface

// File: sv/elf_hash_bin_index_core.sv
// a key_end item pushes its hash into the queue; the back pops the next one only when idle
// key elements are taken one per cycle unless the queue is full; the hash step is combinational
// each key end takes the back through idle, div and done: a radix-2 divider, one bit per cycle
// a 4-deep queue of finished hashes sits between front and back
// reset: synchronous active-low rst_n clears accumulator, queue pointers, divider state, bin_count to 1
`include "elf_hash_bin_index_core_assert.svh"

module elf_hash_bin_index_core #(
  parameter int QUEUE_DEPTH = ehbi_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ehbi_in_if.sink                    in_item,
  ehbi_out_if.source                 out_item,
  input  logic                       cfg_wr_en,
  input  logic [ehbi_pkg::BIN_W-1:0] cfg_wr_data
);

  logic [ehbi_pkg::BIN_W-1:0]  bin_count_r;
  logic                        push;
  logic                        pop;
  logic [ehbi_pkg::HASH_W-1:0] push_data;
  logic [ehbi_pkg::HASH_W-1:0] pop_data;
  ehbi_pkg::q_stat_t           q_stat;
  logic                        in_last_acc;

  assign in_last_acc = in_item.valid && in_item.ready && in_item.key_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= ehbi_pkg::BIN_COUNT_RESET;
    end else if (cfg_wr_en) begin
      bin_count_r <= cfg_wr_data;
    end
  end

  ehbi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ehbi_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ehbi_pkg::HASH_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  ehbi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .bin_count (bin_count_r),
    .out_item  (out_item)
  );

  `EHBI_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !q_stat.full, "push into full queue")
  `EHBI_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
  `EHBI_ASSERT_NEXT(a_key_end_queued, clk, rst_n, in_last_acc, !q_stat.empty, "key end not queued")

endmodule

// File: sv/ehbi_front.sv
module ehbi_front (
  input  logic                         clk,
  input  logic                         rst_n,
  ehbi_in_if.sink                      in_item,
  input  ehbi_pkg::q_stat_t            q_stat,
  output logic                         push,
  output logic [ehbi_pkg::HASH_W-1:0]  push_data
);

  logic [ehbi_pkg::HASH_W-1:0] acc_r;
  logic [ehbi_pkg::HASH_W-1:0] acc_nxt;
  logic [ehbi_pkg::HASH_W-1:0] acc_upd;
  logic                        accept;

  assign in_item.ready = !q_stat.full;
  assign accept        = in_item.valid && in_item.ready;

  always_comb begin
    if (in_item.element_present) begin
      acc_upd = ehbi_pkg::hash_step(acc_r, in_item.key_element);
    end else begin
      acc_upd = acc_r;
    end
  end

  assign push      = accept && in_item.key_end;
  assign push_data = acc_upd;

  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = in_item.key_end ? '0 : acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: sv/ehbi_queue.sv
module ehbi_queue #(
  parameter int DEPTH = ehbi_pkg::QUEUE_DEPTH,
  parameter int WIDTH = ehbi_pkg::HASH_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  pop_data,
  output ehbi_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: sv/ehbi_back.sv
module ehbi_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ehbi_pkg::q_stat_t           q_stat,
  input  logic [ehbi_pkg::HASH_W-1:0] pop_data,
  output logic                        pop,
  input  logic [ehbi_pkg::BIN_W-1:0]  bin_count,
  ehbi_out_if.source                  out_item
);

  localparam int HW    = ehbi_pkg::HASH_W;
  localparam int BW    = ehbi_pkg::BIN_W;
  localparam int CNT_W = $clog2(HW);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(HW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t          state_r;
  logic [HW-1:0]   dvd_r;
  logic [BW-1:0]   dvs_r;
  logic [BW-1:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic            zero_r;
  logic            out_valid_r;
  logic [BW-1:0]   out_bin_r;

  logic [BW:0]     rem_sh;
  logic [BW:0]     rem_sub;
  logic [BW-1:0]   rem_step;
  logic [BW-1:0]   odd_div;
  logic            out_free;
  logic            out_load;

  assign odd_div  = bin_count[0] ? bin_count : bin_count - 1'b1;
  assign rem_sh   = {rem_r, dvd_r[HW-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign rem_step = rem_sub[BW] ? rem_sh[BW-1:0] : rem_sub[BW-1:0];
  assign out_free = !out_valid_r || out_item.ready;
  assign out_load = (state_r == S_DONE) && out_free;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty;

  assign out_item.valid     = out_valid_r;
  assign out_item.bin_index = out_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_item.ready);
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            dvd_r   <= pop_data;
            dvs_r   <= odd_div;
            zero_r  <= (bin_count == '0);
            rem_r   <= '0;
            cnt_r   <= LAST_BIT;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_step;
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_bin_r   <= zero_r ? '0 : rem_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/elf_hash_bin_index_checker.sv
`timescale 1ns / 100ps

module elf_hash_bin_index_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  ehbi_in_if                         in_mon,
  ehbi_out_if                        out_mon,
  input  logic                       cfg_wr_en,
  input  logic [ehbi_pkg::BIN_W-1:0] cfg_wr_data,
  output int                         pending_bins,
  output int                         fail_count
);

  logic [ehbi_pkg::HASH_W-1:0] hash_acc;
  logic [ehbi_pkg::BIN_W-1:0]  bin_count;
  logic [ehbi_pkg::BIN_W-1:0]  expected_bins[$];
  logic [ehbi_pkg::BIN_W-1:0]  want_bin;

  function automatic logic [ehbi_pkg::HASH_W-1:0] elf_step(
      input logic [ehbi_pkg::HASH_W-1:0] acc,
      input logic [ehbi_pkg::HASH_W-1:0] elem);
    logic [ehbi_pkg::HASH_W-1:0] mixed;
    mixed = {acc[ehbi_pkg::HASH_W-5:0], 4'b0000} + elem;
    mixed = mixed ^ {24'd0, mixed[31:28], 4'b0000};
    mixed[31:28] = 4'b0000;
    return mixed;
  endfunction

  function automatic logic [ehbi_pkg::BIN_W-1:0] bin_of(
      input logic [ehbi_pkg::HASH_W-1:0] acc,
      input logic [ehbi_pkg::BIN_W-1:0] count);
    logic [ehbi_pkg::HASH_W-1:0] divisor;
    if (count == '0) begin
      return '0;
    end
    divisor = {1'b0, count};
    if (!count[0]) begin
      divisor = divisor - 1;
    end
    return ehbi_pkg::BIN_W'(acc % divisor);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hash_acc = '0;
      bin_count = ehbi_pkg::BIN_COUNT_RESET;
      expected_bins.delete();
    end else begin
      if (cfg_wr_en) begin
        bin_count = cfg_wr_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.element_present) begin
          hash_acc = elf_step(hash_acc, in_mon.key_element);
        end
        if (in_mon.key_end) begin
          expected_bins.push_back(bin_of(hash_acc, bin_count));
          hash_acc = '0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bins.size() == 0) begin
          fail_count++;
          $error("bin_index: expected nothing, actual %0d", out_mon.bin_index);
        end else begin
          want_bin = expected_bins.pop_front();
          if (out_mon.bin_index !== want_bin) begin
            fail_count++;
            $error("bin_index: expected %0d, actual %0d", want_bin, out_mon.bin_index);
          end
        end
      end
    end
    pending_bins = expected_bins.size();
  end

endmodule

// File: dv/tb_elf_hash_bin_index_core.sv
`timescale 1ns / 100ps

module tb_elf_hash_bin_index_core;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 150;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en;
  logic [ehbi_pkg::BIN_W-1:0] cfg_wr_data;
  int                         pending_bins;
  int                         fail_count;
  int                         stall_cycles = 0;
  logic                       tx_gaps = 1'b1;
  logic                       rx_steady = 1'b0;
  logic                       hold_req = 1'b0;

  ehbi_in_if  in_item();
  ehbi_out_if out_item();

  elf_hash_bin_index_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  elf_hash_bin_index_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_item),
    .out_mon      (out_item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .pending_bins (pending_bins),
    .fail_count   (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random stalls, steady stretches and one long hold-off
  initial begin
    out_item.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_item.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_item.ready <= rx_steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  task automatic push_key_item(input logic [ehbi_pkg::HASH_W-1:0] elem, input logic present,
                               input logic last);
    while (tx_gaps && $urandom_range(0, 99) < 33) begin
      in_item.valid <= 1'b0;
      @(negedge clk);
    end
    in_item.valid           <= 1'b1;
    in_item.key_element     <= elem;
    in_item.element_present <= present;
    in_item.key_end         <= last;
    do @(posedge clk); while (!(in_item.valid && in_item.ready));
    @(negedge clk);
  endtask

  function automatic logic [ehbi_pkg::HASH_W-1:0] pick_element();
    int       sel;
    logic [7:0] ch;
    sel = $urandom_range(0, 99);
    ch = $urandom;
    if (sel < 45) begin
      return $urandom_range(32, 126);
    end
    if (sel < 60) begin
      return {{24{ch[7]}}, ch};
    end
    return $urandom;
  endfunction

  task automatic send_random_key(inout int count);
    int   len;
    logic absent_end;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    absent_end = (len == 0) || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      // noise: absent element inside a key
      if ($urandom_range(0, 9) == 0) begin
        push_key_item($urandom, 1'b0, 1'b0);
      end
      push_key_item(pick_element(), 1'b1, (i == len - 1) && !absent_end);
      count++;
    end
    if (absent_end) begin
      push_key_item($urandom, 1'b0, 1'b1);
      count++;
    end
  endtask

  task automatic random_phase(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      send_random_key(sent);
    end
  endtask

  task automatic wait_idle();
    in_item.valid <= 1'b0;
    while (pending_bins != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_bin_count(input logic [ehbi_pkg::BIN_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [ehbi_pkg::BIN_W-1:0] bin_settings[8];
    in_item.valid           = 1'b0;
    in_item.key_element     = '0;
    in_item.element_present = 1'b0;
    in_item.key_end         = 1'b0;
    cfg_wr_en               = 1'b0;
    cfg_wr_data             = '0;

    bin_settings[0] = 31'h7fff_ffff;
    bin_settings[1] = 31'd2;
    bin_settings[2] = 31'd0;
    bin_settings[3] = 31'd3;
    bin_settings[4] = 31'h7fff_fffe;
    bin_settings[5] = ehbi_pkg::BIN_W'($urandom) | 31'd1;
    bin_settings[6] = ehbi_pkg::BIN_W'($urandom);
    bin_settings[7] = ehbi_pkg::BIN_W'($urandom_range(1, 64));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset bin count
    random_phase(60);
    wait_idle();
    write_bin_count(31'h7fff_ffff);

    // directed
    push_key_item(32'h1234_5678, 1'b0, 1'b1);
    push_key_item(32'hdead_beef, 1'b0, 1'b0);
    push_key_item(32'hffff_ffff, 1'b0, 1'b1);
    push_key_item(32'h0000_0000, 1'b1, 1'b1);
    push_key_item(32'hffff_ffff, 1'b1, 1'b1);
    push_key_item(32'h8000_0000, 1'b1, 1'b1);
    push_key_item(32'h7fff_ffff, 1'b1, 1'b1);
    repeat (9) push_key_item(32'h0000_007f, 1'b1, 1'b0);
    push_key_item(32'h0000_0000, 1'b0, 1'b1);
    for (int i = 0; i < 3; i++) begin
      push_key_item(32'hffff_ff80, 1'b1, i == 2);
    end

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_bin_count(bin_settings[p]);
      tx_gaps   = (p != 1);
      rx_steady = (p == 1);
      hold_req  = (p == 3);
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
